// ===== hw/rtl/lhr_pkg.sv =====
// ----------------------------------------------------------------------------
// lhr_pkg
// Shared types and constants for the largest histogram rectangle block.
// ----------------------------------------------------------------------------
`default_nettype none

package lhr_pkg;

    // width of the height field on the input stream
    localparam int HEIGHT_IN_BITS = 16;
    localparam int S_TDATA_BITS   = 16;

    // result area field, saturating
    localparam int AREA_BITS    = 26;
    localparam int M_TDATA_BITS = 32;
    localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_LOAD,
        ST_FLUSH,
        ST_FLOAD,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/lhr_ram.sv =====
// ----------------------------------------------------------------------------
// lhr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/largest_histogram_rectangle.sv =====
// ----------------------------------------------------------------------------
// largest_histogram_rectangle
// Largest rectangle under a streamed histogram, monotonic stack in RAM.
// ----------------------------------------------------------------------------
// Columns arrive on the slave stream, one height per transaction in tdata,
// with tlast on the final column of a histogram. On that column the block
// sends one transaction on the master stream: the largest area under a run
// of consecutive columns (saturated to 26 bits) and an overflow flag in
// tuser, set when more than MAX_COLUMNS columns arrived (extra ones dropped).
// The open rectangles sit in one RAM (height, start); the top entry is held
// in registers. A column is taken in IDLE and compared with the top in POP;
// each popped entry adds a LOAD (one RAM read, one load) unless it empties
// the stack, and the final flush takes each remaining entry through FLUSH,
// and FLOAD for all but the last, before DONE loads the output register.
// Reset clears the stack count, column index, best area and output valid;
// RAM contents need no clearing. The result waits in an output register;
// while it is stalled the block keeps taking columns of the next histogram
// and only holds at the end of that one until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module largest_histogram_rectangle
    import lhr_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [S_TDATA_BITS-1:0] s_axis_tdata,  // [15:0] height
    input  wire logic                    s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic      [M_TDATA_BITS-1:0] m_axis_tdata,  // [25:0] max_area, then zero pad
    output logic                         m_axis_tuser   // [0] overflow
);

    localparam int HB = (HEIGHT_BITS < HEIGHT_IN_BITS) ? HEIGHT_BITS : HEIGHT_IN_BITS;
    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int PW = HB + CW;
    localparam int RW = HB + AW;

    t_state r_state, n_state;

    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_col, n_col;
    logic [PW-1:0]        r_best, n_best;
    logic                 r_ovf, n_ovf;
    logic [HB-1:0]        r_h, n_h;
    logic                 r_last, n_last;
    logic [AW-1:0]        r_start, n_start;
    logic [HB-1:0]        r_top_h, n_top_h;
    logic [AW-1:0]        r_top_s, n_top_s;
    logic [PW-1:0]        r_prod, n_prod;
    logic                 r_prod_vld, n_prod_vld;
    logic                 r_out_vld, n_out_vld;
    logic [AREA_BITS-1:0] r_out_area, n_out_area;
    logic                 r_out_ovf, n_out_ovf;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [RW-1:0]        ram_rdata;
    logic [CW-1:0]        span;
    logic [CW-1:0]        count_m1;
    logic [CW-1:0]        count_m2;
    logic [PW-1:0]        best_fold;
    logic                 out_free;
    logic                 in_acc;

    lhr_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_COLUMNS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_top_s, r_top_h}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign count_m1  = r_count - CW'(1);
    assign count_m2  = r_count - CW'(2);
    assign ram_waddr = count_m1[AW-1:0];
    assign ram_raddr = count_m2[AW-1:0];
    assign span      = r_col - CW'(r_top_s);
    assign best_fold = (r_prod_vld && (r_prod > r_best)) ? r_prod : r_best;
    assign out_free  = !r_out_vld || m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = M_TDATA_BITS'(r_out_area);
    assign m_axis_tuser  = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_col      <= '0;
            r_best     <= '0;
            r_ovf      <= 1'b0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_col      <= n_col;
            r_best     <= n_best;
            r_ovf      <= n_ovf;
            r_prod_vld <= n_prod_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h        <= n_h;
        r_last     <= n_last;
        r_start    <= n_start;
        r_top_h    <= n_top_h;
        r_top_s    <= n_top_s;
        r_prod     <= n_prod;
        r_out_area <= n_out_area;
        r_out_ovf  <= n_out_ovf;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_col      = r_col;
        n_ovf      = r_ovf;
        n_h        = r_h;
        n_last     = r_last;
        n_start    = r_start;
        n_top_h    = r_top_h;
        n_top_s    = r_top_s;
        n_prod     = PW'(r_top_h) * PW'(span);
        n_prod_vld = 1'b0;
        n_best     = best_fold;
        n_out_vld  = r_out_vld && !m_axis_tready;
        n_out_area = r_out_area;
        n_out_ovf  = r_out_ovf;
        ram_we     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_h     = s_axis_tdata[HB-1:0];
                    n_last  = s_axis_tlast;
                    n_start = r_col[AW-1:0];
                    if (r_col == CW'(MAX_COLUMNS)) begin
                        // drop the column, still flush on last
                        n_ovf   = 1'b1;
                        n_state = s_axis_tlast ? ST_FLUSH : ST_IDLE;
                    end else begin
                        n_state = ST_POP;
                    end
                end
            end
            ST_POP: begin
                if ((r_count != '0) && (r_top_h >= r_h)) begin
                    // close the top rectangle, inherit its start
                    n_prod_vld = 1'b1;
                    n_start    = r_top_s;
                    n_count    = count_m1;
                    n_state    = (count_m1 != '0) ? ST_LOAD : ST_POP;
                end else begin
                    // spill the old top to RAM, push the new column
                    ram_we  = (r_count != '0);
                    n_top_h = r_h;
                    n_top_s = r_start;
                    n_count = r_count + CW'(1);
                    n_col   = r_col + CW'(1);
                    n_state = r_last ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_LOAD: begin
                n_top_h = ram_rdata[HB-1:0];
                n_top_s = ram_rdata[RW-1:HB];
                n_state = ST_POP;
            end
            ST_FLUSH: begin
                if (r_count != '0) begin
                    n_prod_vld = 1'b1;
                    n_count    = count_m1;
                    n_state    = (count_m1 != '0) ? ST_FLOAD : ST_FLUSH;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_FLOAD: begin
                n_top_h = ram_rdata[HB-1:0];
                n_top_s = ram_rdata[RW-1:HB];
                n_state = ST_FLUSH;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_area = (best_fold > PW'(AREA_MAX)) ? AREA_MAX
                                                             : AREA_BITS'(best_fold);
                    n_out_ovf  = r_ovf;
                    n_count    = '0;
                    n_col      = '0;
                    n_best     = '0;
                    n_ovf      = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/tb_largest_histogram_rectangle.sv =====
// ----------------------------------------------------------------------------
// tb_largest_histogram_rectangle
// Self-checking bench for the streamed largest histogram rectangle block.
// ----------------------------------------------------------------------------
// Columns go in on the slave stream, one per transaction. A local monotonic
// stack model predicts the area and the overflow flag of every histogram when
// its last column is taken. Each result transaction is checked against the
// oldest prediction. Directed histograms cover the field extremes, equal,
// rising and falling runs and a deep stack with a long flush. They are
// followed by random histograms of mixed shapes, with random gaps on both
// streams, a long output stall and a final stretch with no gaps at all.
// ----------------------------------------------------------------------------

module tb_largest_histogram_rectangle
    import lhr_pkg::*;
();

    localparam int MAX_COLS     = 1024;
    localparam int DEEP_COLS    = 80;
    localparam int RANDOM_ITEMS = 280;
    localparam int DRAIN_LIMIT  = 20000;

    typedef struct packed {
        logic [AREA_BITS-1:0] area;
        logic                 ovf;
    } t_rect_result;

    typedef enum {
        SHAPE_RANDOM,
        SHAPE_LOW,
        SHAPE_RISING,
        SHAPE_FALLING
    } t_hist_shape;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_TDATA_BITS-1:0] s_axis_tdata  = '0;  // [15:0] height
    logic                    s_axis_tlast  = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_axis_tdata;        // [25:0] max_area, then zero pad
    logic                    m_axis_tuser;        // [0] overflow

    // model of the column stack
    logic [15:0]     col_height [MAX_COLS];
    logic [10:0]     col_start  [MAX_COLS];
    int              open_count;
    int              col_count;
    longint          best_rect;
    logic            cols_dropped;
    t_rect_result    expected_rects [$];

    int   errors        = 0;
    bit   tx_jitter     = 1'b1;
    bit   rx_jitter     = 1'b1;
    int   rx_long_hold  = 0;
    int   rx_stall_left = 0;

    largest_histogram_rectangle dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void score_rect(input logic [15:0] h, input int span);
        longint area;
        area = longint'(h) * span;
        if (area > best_rect) best_rect = area;
    endfunction

    // advance the stack model by one accepted column
    function automatic void absorb_column(input logic [15:0] h, input logic last);
        logic [10:0]  start;
        t_rect_result res;
        if (col_count >= MAX_COLS) begin
            cols_dropped = 1'b1;
        end else begin
            start = col_count[10:0];
            while (open_count > 0 && col_height[open_count-1] >= h) begin
                open_count--;
                score_rect(col_height[open_count], col_count - int'(col_start[open_count]));
                start = col_start[open_count];
            end
            if (open_count < MAX_COLS) begin
                col_height[open_count] = h;
                col_start[open_count]  = start;
                open_count++;
            end
            col_count++;
        end
        if (last) begin
            while (open_count > 0) begin
                open_count--;
                score_rect(col_height[open_count], col_count - int'(col_start[open_count]));
            end
            res.area = (best_rect > longint'(AREA_MAX)) ? AREA_MAX : best_rect[AREA_BITS-1:0];
            res.ovf  = cols_dropped;
            expected_rects.push_back(res);
            open_count   = 0;
            col_count    = 0;
            best_rect    = 0;
            cols_dropped = 1'b0;
        end
    endfunction

    task automatic check_result();
        t_rect_result want;
        if (expected_rects.size() == 0) begin
            report_mismatch("result with nothing pending", m_axis_tdata, 0);
        end else begin
            want = expected_rects.pop_front();
            if (m_axis_tdata[AREA_BITS-1:0] !== want.area)
                report_mismatch("max_area", m_axis_tdata[AREA_BITS-1:0], want.area);
            if (m_axis_tdata[M_TDATA_BITS-1:AREA_BITS] !== '0)
                report_mismatch("tdata pad", m_axis_tdata[M_TDATA_BITS-1:AREA_BITS], 0);
            if (m_axis_tuser !== want.ovf)
                report_mismatch("overflow", m_axis_tuser, want.ovf);
        end
    endtask

    // result side: check each transaction, then pick tready for the next edge
    always @(posedge i_clk) begin : rx_side
        logic ready_next;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result();
        ready_next = 1'b1;
        if (rx_long_hold > 0) begin
            ready_next = 1'b0;
            rx_long_hold--;
        end else if (rx_stall_left > 0) begin
            ready_next = 1'b0;
            rx_stall_left--;
        end else if (rx_jitter && $urandom_range(0, 4) == 0) begin
            rx_stall_left = $urandom_range(1, 5) - 1;
            ready_next = 1'b0;
        end
        m_axis_tready <= ready_next;
    end

    // offer one column; returns at the edge of acceptance or after a gap
    task automatic push_column(input logic [15:0] h, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= h;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_column(h, last);
        if (tx_jitter && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // drop tvalid and hold until every pending result has come back
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && expected_rects.size() != 0; n++)
            @(posedge i_clk);
    endtask

    task automatic send_histogram(input int len, input t_hist_shape shape);
        int v;
        v = (shape == SHAPE_FALLING) ? 65535 - int'($urandom_range(0, 4000))
                                     : int'($urandom_range(0, 3000));
        for (int i = 0; i < len; i++) begin
            case (shape)
                SHAPE_LOW:     v = $urandom_range(0, 3);
                SHAPE_RISING:  v = v + int'($urandom_range(0, 3000));
                SHAPE_FALLING: v = v - int'($urandom_range(0, 3000));
                default:       v = $urandom_range(0, 65535);
            endcase
            if (v > 65535) v = 65535;
            if (v < 0) v = 0;
            push_column(v[15:0], i == len - 1);
        end
    endtask

    task automatic test_directed();
        // single-column histograms at the height extremes
        push_column(16'd0, 1'b1);
        push_column(16'hFFFF, 1'b1);
        push_column(16'd1, 1'b1);
        // tall columns split by a zero
        push_column(16'hFFFF, 1'b0);
        push_column(16'd0, 1'b0);
        push_column(16'hFFFF, 1'b0);
        push_column(16'hFFFF, 1'b1);
        // all zero heights
        push_column(16'd0, 1'b0);
        push_column(16'd0, 1'b0);
        push_column(16'd0, 1'b1);
        // equal heights pop on every column after the first
        for (int i = 0; i < 4; i++) push_column(16'd5, i == 3);
        // rising run keeps everything open until the flush
        for (int i = 1; i <= 5; i++) push_column(16'(i), i == 5);
        // falling run pops one entry per column after the first
        for (int i = 5; i >= 1; i--) push_column(16'(i), i == 1);
        wait_drain();
    endtask

    task automatic test_deep_stack();
        // long rising run: every column stays open until a deep flush
        for (int i = 0; i < DEEP_COLS; i++) push_column(16'(i * 63), i == DEEP_COLS - 1);
        wait_drain();
        // long run at full height pops one entry per column after the first
        for (int i = 0; i < DEEP_COLS; i++) push_column(16'hFFFF, i == DEEP_COLS - 1);
        wait_drain();
    endtask

    task automatic test_output_stall();
        tx_jitter    = 1'b0;
        rx_long_hold = 400;
        // keep offering while results back up, so the input stalls
        for (int k = 0; k < 4; k++) send_histogram(10, SHAPE_RANDOM);
        wait_drain();
        tx_jitter = 1'b1;
    endtask

    task automatic test_random_histograms();
        int sent;
        int len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 24);
            tx_jitter = $urandom_range(0, 3) != 0;
            rx_jitter = $urandom_range(0, 3) != 0;
            send_histogram(len, t_hist_shape'($urandom_range(0, 3)));
            sent += len;
            if ($urandom_range(0, 9) == 0) wait_drain();
        end
        wait_drain();
    endtask

    task automatic test_back_to_back();
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        for (int k = 0; k < 6; k++)
            send_histogram($urandom_range(1, 12), t_hist_shape'($urandom_range(0, 3)));
        wait_drain();
    endtask

    initial begin
        open_count   = 0;
        col_count    = 0;
        best_rect    = 0;
        cols_dropped = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_deep_stack();
        test_output_stall();
        test_random_histograms();
        test_back_to_back();

        repeat (40) @(posedge i_clk);
        if (expected_rects.size() != 0)
            report_mismatch("results never arrived", 0, expected_rects.size());
        if (errors == 0) begin
            $display("largest_histogram_rectangle test passed");
        end else begin
            $display("largest_histogram_rectangle test failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("largest_histogram_rectangle test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lhr_pkg.sv
hw/rtl/lhr_ram.sv
hw/rtl/largest_histogram_rectangle.sv
tb/tb_largest_histogram_rectangle.sv
